>>> rtl/shs_pkg.sv
`default_nettype none
package shs_pkg;

   // SHA-1 round constants
   localparam logic [31:0] K_ROUND_0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND_3 = 32'hCA62C1D6;

   // Initial chaining words
   localparam logic [31:0] IV_WORD_0 = 32'h67452301;
   localparam logic [31:0] IV_WORD_1 = 32'hEFCDAB89;
   localparam logic [31:0] IV_WORD_2 = 32'h98BADCFE;
   localparam logic [31:0] IV_WORD_3 = 32'h10325476;
   localparam logic [31:0] IV_WORD_4 = 32'hC3D2E1F0;

   localparam int BLOCK_WORDS = 16;
   localparam int DIGEST_WORDS = 5;
   localparam int ROUNDS = 80;
   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);

   typedef logic [31:0] word_type;

   // Control from the sequencer to the datapath
   typedef struct packed {
      logic       absorb;
      logic       word_done;
      logic       round_en;
      logic [6:0] round_t;
      logic       load_work;
      logic       add_chain;
      logic       init_chain;
   } ctl_type;

   function automatic word_type round_k(input logic [6:0] t);
      word_type k;
      if (t < 7'd20) k = K_ROUND_0;
      else if (t < 7'd40) k = K_ROUND_1;
      else if (t < 7'd60) k = K_ROUND_2;
      else k = K_ROUND_3;
      return k;
   endfunction

   function automatic word_type round_f(input logic [6:0] t, input word_type b,
                                        input word_type c, input word_type d);
      word_type f;
      if (t < 7'd20) f = (b & c) | (~b & d);
      else if (t < 7'd40) f = b ^ c ^ d;
      else if (t < 7'd60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      return f;
   endfunction

   function automatic word_type iv_word(input logic [2:0] idx);
      word_type w;
      case (idx)
         3'd0: w = IV_WORD_0;
         3'd1: w = IV_WORD_1;
         3'd2: w = IV_WORD_2;
         3'd3: w = IV_WORD_3;
         default: w = IV_WORD_4;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

>>> rtl/shs_schedule.sv
`default_nettype none
module shs_schedule
   import shs_pkg::*;
(
   input  wire logic     clock,
   input  wire ctl_type  ctl,
   input  wire logic [7:0] byte_value,
   output word_type      w_t
);

   logic [23:0] acc_ff;
   word_type    sched_ff [BLOCK_WORDS];
   word_type    expand;

   // Expand the rolling schedule from its fixed taps
   assign expand = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
   assign w_t = (ctl.round_t < 7'(BLOCK_WORDS)) ? sched_ff[0]
                                                 : {expand[30:0], expand[31]};

   // Pack bytes big-endian and shift whole words into the schedule
   always_ff @(posedge clock) begin
      if (ctl.absorb) begin
         acc_ff <= {acc_ff[15:0], byte_value};
         if (ctl.word_done) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) sched_ff[i] <= sched_ff[i + 1];
            sched_ff[BLOCK_WORDS - 1] <= {acc_ff, byte_value};
         end
      end else if (ctl.round_en) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) sched_ff[i] <= sched_ff[i + 1];
         sched_ff[BLOCK_WORDS - 1] <= w_t;
      end
   end

endmodule
`default_nettype wire

>>> rtl/shs_compress.sv
`default_nettype none
module shs_compress
   import shs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire ctl_type    ctl,
   input  wire word_type   w_t,
   input  wire logic [2:0] rd_idx,
   output word_type        digest
);

   word_type a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type chain_ff [DIGEST_WORDS];
   word_type temp;

   // One round through the shared adder
   assign temp = {a_ff[26:0], a_ff[31:27]} + round_f(ctl.round_t, b_ff, c_ff, d_ff)
                 + e_ff + round_k(ctl.round_t) + w_t;

   // Advance the working words
   always_ff @(posedge clock) begin
      if (ctl.load_work) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (ctl.round_en) begin
         a_ff <= temp;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   // Hold the chaining words; fold in each finished block
   always_ff @(posedge clock) begin
      if (reset || ctl.init_chain) begin
         for (int i = 0; i < DIGEST_WORDS; i++) chain_ff[i] <= iv_word(3'(i));
      end else if (ctl.add_chain) begin
         chain_ff[0] <= chain_ff[0] + a_ff;
         chain_ff[1] <= chain_ff[1] + b_ff;
         chain_ff[2] <= chain_ff[2] + c_ff;
         chain_ff[3] <= chain_ff[3] + d_ff;
         chain_ff[4] <= chain_ff[4] + e_ff;
      end
   end

   // Select the digest word for the output
   always_comb begin
      case (rd_idx)
         3'd0: digest = chain_ff[0];
         3'd1: digest = chain_ff[1];
         3'd2: digest = chain_ff[2];
         3'd3: digest = chain_ff[3];
         default: digest = chain_ff[4];
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/sha1_stream_hasher_unit.sv
`default_nettype none
// SHA-1 stream hasher.
// Input channel req_*: one item per handshake; req_tdata carries a message
// byte, req_tuser[0] says the byte is present and req_tlast ends the message.
// An item with neither a byte nor an end changes nothing.
// The byte that completes a 64-byte block starts the compression: 80
// rounds through one shared round adder, one round a cycle, then a fold
// into the chaining words, and req_tready is low after every 64th byte
// until the fold is done.
// At the end of a message the sequencer feeds 0x80, zero bytes and the
// 64-bit bit count through the same byte path, one byte a cycle, with one
// or two compressions on the way, and then offers the digest on rsp_*:
// five words, most significant first, last on rsp_tlast.
// While the receiver stalls, the current word holds and no item is taken.
// After the fifth word the block is idle, chaining words and bit count reinitialised.
// Reset loads the standard initial chaining words and clears the bit count;
// req_tready is high from the first clock edge under reset onwards.
module sha1_stream_hasher_unit
   import shs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic [0:0]  req_tuser,   // byte_valid
   input  wire logic        req_tlast,   // end_of_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // digest_word[31:0], word_index[34:32], zero fill
   output logic             rsp_tlast    // last_word
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_ADDC  = 3'd2;
   localparam logic [2:0] ST_PAD   = 3'd3;
   localparam logic [2:0] ST_LEN   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] bit_length_ff, bit_length_in;
   logic [6:0]  round_ff, round_in;
   logic        fin_ff, fin_in;
   logic        sent80_ff, sent80_in;
   logic [3:0]  len_cnt_ff, len_cnt_in;
   logic [2:0]  out_idx_ff, out_idx_in;

   ctl_type     ctl;
   logic [7:0]  byte_value;
   logic [2:0]  len_sel;
   word_type    w_t;
   word_type    digest;

   assign len_sel  = 3'd7 - len_cnt_ff[2:0];

   // Sequence absorb, rounds, padding and digest output
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      bit_length_in = bit_length_ff;
      round_in      = round_ff;
      fin_in        = fin_ff;
      sent80_in     = sent80_ff;
      len_cnt_in    = len_cnt_ff;
      out_idx_in    = out_idx_ff;
      byte_value    = req_tdata;
      ctl           = '0;
      ctl.round_t   = round_ff;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser[0]) begin
                  ctl.absorb    = 1'b1;
                  bit_length_in = bit_length_ff + 64'd8;
               end
               if (req_tlast) begin
                  fin_in    = 1'b1;
                  sent80_in = 1'b0;
                  state_in  = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            ctl.round_en = 1'b1;
            round_in     = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) state_in = ST_ADDC;
         end
         ST_ADDC: begin
            ctl.add_chain = 1'b1;
            if (!fin_ff) state_in = ST_IDLE;
            else if (len_cnt_ff == 4'd8) begin
               out_idx_in = 3'd0;
               state_in   = ST_OUT;
            end else state_in = ST_PAD;
         end
         ST_PAD: begin
            if (!sent80_ff) begin
               byte_value = PAD_MARK;
               ctl.absorb = 1'b1;
               sent80_in  = 1'b1;
            end else if (pos_ff == LEN_POS) begin
               len_cnt_in = 4'd0;
               state_in   = ST_LEN;
            end else begin
               byte_value = 8'h00;
               ctl.absorb = 1'b1;
            end
         end
         ST_LEN: begin
            byte_value = bit_length_ff[{len_sel, 3'b000} +: 8];
            ctl.absorb = 1'b1;
            len_cnt_in = len_cnt_ff + 4'd1;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'(DIGEST_WORDS - 1)) begin
                  ctl.init_chain = 1'b1;
                  bit_length_in  = 64'd0;
                  fin_in         = 1'b0;
                  sent80_in      = 1'b0;
                  len_cnt_in     = 4'd0;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Advance the byte position; a full block starts the rounds
      if (ctl.absorb) begin
         ctl.word_done = (pos_ff[1:0] == 2'b11);
         pos_in        = pos_ff + 6'd1;
         if (pos_ff == LAST_POS) begin
            ctl.load_work = 1'b1;
            round_in      = 7'd0;
            state_in      = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= 6'd0;
         bit_length_ff <= 64'd0;
         round_ff      <= 7'd0;
         fin_ff        <= 1'b0;
         sent80_ff     <= 1'b0;
         len_cnt_ff    <= 4'd0;
         out_idx_ff    <= 3'd0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         bit_length_ff <= bit_length_in;
         round_ff      <= round_in;
         fin_ff        <= fin_in;
         sent80_ff     <= sent80_in;
         len_cnt_ff    <= len_cnt_in;
         out_idx_ff    <= out_idx_in;
      end
   end

   shs_schedule u_schedule (
      .clock      (clock),
      .ctl        (ctl),
      .byte_value (byte_value),
      .w_t        (w_t)
   );

   shs_compress u_compress (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .w_t    (w_t),
      .rd_idx (out_idx_ff),
      .digest (digest)
   );

   // Drive the digest word with its index
   assign rsp_tdata = {5'b00000, out_idx_ff, digest};
   assign rsp_tlast = (out_idx_ff == 3'(DIGEST_WORDS - 1));

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while digest pending");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("not idle after last digest word");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == LAST_ROUND) |=> (state_ff == ST_ADDC))
      else $error("compression did not end after last round");
`endif

endmodule
`default_nettype wire
